FILE: src/gig_pkg.sv
package gig_pkg;

  // Width of one input component.
  localparam int unsigned CompBits = 31;
  // Remainder components stay within sqrt(2) times the largest input magnitude.
  localparam int unsigned ValBits  = CompBits + 2;
  // Products, norms and cross sums.
  localparam int unsigned ProdBits = 2 * ValBits;
  // Result component width.
  localparam int unsigned OutBits  = 32;
  // Restoring-divider iterations, one quotient bit per cycle.
  localparam int unsigned DivSteps = ProdBits + 1;
  localparam int unsigned DcntBits = $clog2(DivSteps + 1);

  typedef logic signed [ValBits-1:0]  val_t;
  typedef logic signed [ProdBits-1:0] prod_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_X,
    ST_NORM_Y,
    ST_CHECK,
    ST_NUM,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_REM,
    ST_DONE
  } gig_state_t;

endpackage

FILE: src/gaussian_integer_gcd_unit.sv
// Gaussian integer gcd. One transfer on the in_ channel carries x and y; the
// block runs the Euclidean algorithm with nearest-integer quotients (each
// component rounded half away from zero, exact integer arithmetic) and makes
// one out_ transfer with the gcd as the loop leaves it (not normalized to an
// associate) and a coprime flag that is set when the gcd is +-1 or +-i. If
// one operand is zero the other is returned; if both are zero the result is
// zero. The operand with the larger norm is the dividend, x on a tie.
// Timing: in_stall is low only while the sequencer is idle. A finished result
// sits in the output register; the next item may be taken and computed while
// it waits, and that item holds in its final state until the register frees.
// Per item: setup (both norms and the swap check), then per Euclid step the
// cross products, the two quotients on the single restoring divider that
// produces one quotient bit per cycle, the remainder, the new divisor norm
// and the zero check, then loading the result. Each remainder has at most
// half the norm of its divisor, so full-width inputs (norm at most 2^61)
// need at most about 62 steps; small operands finish in a few steps.
// All products go through one registered signed 33x33 multiplier.
module gaussian_integer_gcd_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [gig_pkg::CompBits-1:0] in_x_re,
  input  logic signed [gig_pkg::CompBits-1:0] in_x_im,
  input  logic signed [gig_pkg::CompBits-1:0] in_y_re,
  input  logic signed [gig_pkg::CompBits-1:0] in_y_im,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [gig_pkg::OutBits-1:0]  out_gcd_re,
  output logic signed [gig_pkg::OutBits-1:0]  out_gcd_im,
  output logic                          out_coprime
);
  import gig_pkg::*;

  gig_state_t state_r, state_nxt;

  // Operands: a is the dividend, b the divisor.
  val_t a_re_r, a_im_r, b_re_r, b_im_r;
  val_t a_re_nxt, a_im_nxt, b_re_nxt, b_im_nxt;
  prod_t nx_r, nx_nxt;            // norm of x, then a sentinel
  prod_t d_r, d_nxt;              // divisor norm
  prod_t nre_r, nre_nxt, nim_r, nim_nxt;
  val_t  q_re_r, q_re_nxt, q_im_r, q_im_nxt;
  logic [2:0] ph_r, ph_nxt;       // multiplier phase within a state
  prod_t acc_r, acc_nxt;          // accumulator for sum of products

  // Shared multiplier: operands selected combinationally, product registered.
  val_t  mul_a, mul_b;
  prod_t mul_p_r;

  // Restoring divider: |n|*2 + d divided by 2*d.
  logic [DcntBits-1:0] dcnt_r, dcnt_nxt;
  logic [ProdBits:0]   dnum_r, dnum_nxt;   // dividend shifting out
  logic [ProdBits+1:0] drem_r, drem_nxt;   // partial remainder
  logic [ProdBits:0]   dquo_r, dquo_nxt;
  logic                dneg_r, dneg_nxt;
  logic [ProdBits+1:0] drem_sh, ddiv2;

  // Swap decision and divisor-zero test as seen after the swap.
  logic swap_c, bzero_c;

  logic signed [OutBits-1:0] g_re_r, g_im_r, g_re_nxt, g_im_nxt;
  logic ovalid_r, ovalid_nxt;

  function automatic val_t sx(input logic signed [CompBits-1:0] v);
    sx = val_t'(v);
  endfunction

  // Magnitude of a numerator for the divider start.
  function automatic logic [ProdBits:0] start_num(input prod_t n, input prod_t d);
    logic [ProdBits-1:0] m;
    m = n[ProdBits-1] ? ProdBits'(-n) : n;
    start_num = {m, 1'b0} + {1'b0, d};
  endfunction

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  assign ddiv2   = {1'b0, d_r, 1'b0};
  assign drem_sh = {drem_r[ProdBits:0], dnum_r[ProdBits]};

  assign swap_c  = (nx_r < d_r);
  assign bzero_c = swap_c ? (a_re_r == '0 && a_im_r == '0)
                          : (b_re_r == '0 && b_im_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_NORM_X;
      ST_NORM_X: if (ph_r == 3'd2) state_nxt = ST_NORM_Y;
      ST_NORM_Y: if (ph_r == 3'd2) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = bzero_c ? ST_DONE : ST_NUM;
      ST_NUM:    if (ph_r == 3'd6) state_nxt = ST_DIV_RE;
      ST_DIV_RE: if (dcnt_r == DcntBits'(DivSteps)) state_nxt = ST_DIV_IM;
      ST_DIV_IM: if (dcnt_r == DcntBits'(DivSteps)) state_nxt = ST_REM;
      ST_REM:    if (ph_r == 3'd6) state_nxt = ST_NORM_Y;
      ST_DONE:   if (!ovalid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    a_re_nxt = a_re_r; a_im_nxt = a_im_r; b_re_nxt = b_re_r; b_im_nxt = b_im_r;
    nx_nxt = nx_r; d_nxt = d_r; nre_nxt = nre_r; nim_nxt = nim_r;
    q_re_nxt = q_re_r; q_im_nxt = q_im_r; acc_nxt = acc_r;
    ph_nxt = ph_r + 3'd1;
    dcnt_nxt = dcnt_r; dnum_nxt = dnum_r; drem_nxt = drem_r; dquo_nxt = dquo_r;
    dneg_nxt = dneg_r;
    g_re_nxt = g_re_r; g_im_nxt = g_im_r;
    ovalid_nxt = ovalid_r && out_stall;
    mul_a = a_re_r; mul_b = a_re_r;
    unique case (state_r)
      ST_IDLE: begin
        ph_nxt = '0;
        if (in_valid) begin
          a_re_nxt = sx(in_x_re); a_im_nxt = sx(in_x_im);
          b_re_nxt = sx(in_y_re); b_im_nxt = sx(in_y_im);
        end
      end
      ST_NORM_X: begin
        // ph0: re*re, ph1: im*im, each product lands in the cycle after
        mul_a = (ph_r == 3'd0) ? a_re_r : a_im_r;
        mul_b = mul_a;
        if (ph_r == 3'd1) acc_nxt = mul_p_r;
        if (ph_r == 3'd2) begin
          nx_nxt = acc_r + mul_p_r;
          ph_nxt = '0;
        end
      end
      ST_NORM_Y: begin
        mul_a = (ph_r == 3'd0) ? b_re_r : b_im_r;
        mul_b = mul_a;
        if (ph_r == 3'd1) acc_nxt = mul_p_r;
        if (ph_r == 3'd2) begin
          d_nxt = acc_r + mul_p_r;
          ph_nxt = '0;
        end
      end
      ST_CHECK: begin
        ph_nxt = '0;
        // first pass only: swap if norm(x) < norm(y); later nx_r holds a sentinel
        if (swap_c) begin
          a_re_nxt = b_re_r; a_im_nxt = b_im_r;
          b_re_nxt = a_re_r; b_im_nxt = a_im_r;
          d_nxt = nx_r;
        end
        nx_nxt = '1; // large sentinel: no swap in later steps
        nx_nxt[ProdBits-1] = 1'b0;
      end
      ST_NUM: begin
        // nre = a.re*b.re + a.im*b.im ; nim = a.im*b.re - a.re*b.im
        unique case (ph_r)
          3'd0: begin mul_a = a_re_r; mul_b = b_re_r; end
          3'd1: begin mul_a = a_im_r; mul_b = b_im_r; end
          3'd2: begin mul_a = a_im_r; mul_b = b_re_r; end
          3'd3: begin mul_a = a_re_r; mul_b = b_im_r; end
          default: begin mul_a = a_re_r; mul_b = b_re_r; end
        endcase
        if (ph_r == 3'd1) acc_nxt = mul_p_r;
        if (ph_r == 3'd2) nre_nxt = acc_r + mul_p_r;
        if (ph_r == 3'd3) acc_nxt = mul_p_r;
        if (ph_r == 3'd4) nim_nxt = acc_r - mul_p_r;
        if (ph_r == 3'd6) begin
          dcnt_nxt = '0;
          dnum_nxt = start_num(nre_r, d_r);
          dneg_nxt = nre_r[ProdBits-1];
          drem_nxt = '0; dquo_nxt = '0;
        end
      end
      ST_DIV_RE, ST_DIV_IM: begin
        ph_nxt = '0;
        if (dcnt_r == DcntBits'(DivSteps)) begin
          if (state_r == ST_DIV_RE) begin
            q_re_nxt = dneg_r ? -ValBits'(dquo_r) : ValBits'(dquo_r);
            dcnt_nxt = '0;
            dnum_nxt = start_num(nim_r, d_r);
            dneg_nxt = nim_r[ProdBits-1];
            drem_nxt = '0; dquo_nxt = '0;
          end else begin
            q_im_nxt = dneg_r ? -ValBits'(dquo_r) : ValBits'(dquo_r);
          end
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
          dnum_nxt = {dnum_r[ProdBits-1:0], 1'b0};
          if (drem_sh >= ddiv2) begin
            drem_nxt = drem_sh - ddiv2;
            dquo_nxt = {dquo_r[ProdBits-1:0], 1'b1};
          end else begin
            drem_nxt = drem_sh;
            dquo_nxt = {dquo_r[ProdBits-1:0], 1'b0};
          end
        end
      end
      ST_REM: begin
        // r.re = a.re - (b.re*q.re - b.im*q.im); r.im = a.im - (b.re*q.im + b.im*q.re)
        unique case (ph_r)
          3'd0: begin mul_a = b_re_r; mul_b = q_re_r; end
          3'd1: begin mul_a = b_im_r; mul_b = q_im_r; end
          3'd2: begin mul_a = b_re_r; mul_b = q_im_r; end
          3'd3: begin mul_a = b_im_r; mul_b = q_re_r; end
          default: begin mul_a = b_re_r; mul_b = q_re_r; end
        endcase
        if (ph_r == 3'd1) acc_nxt = mul_p_r;
        if (ph_r == 3'd2) nre_nxt = prod_t'(a_re_r) - (acc_r - mul_p_r);
        if (ph_r == 3'd3) acc_nxt = mul_p_r;
        if (ph_r == 3'd4) nim_nxt = prod_t'(a_im_r) - (acc_r + mul_p_r);
        if (ph_r == 3'd6) begin
          a_re_nxt = b_re_r; a_im_nxt = b_im_r;
          b_re_nxt = ValBits'(nre_r); b_im_nxt = ValBits'(nim_r);
          ph_nxt = '0;
        end
      end
      ST_DONE: begin
        ph_nxt = '0;
        if (!ovalid_r || !out_stall) begin
          g_re_nxt = OutBits'(a_re_r); g_im_nxt = OutBits'(a_im_r);
          ovalid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      ph_r     <= '0;
      dcnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      ph_r     <= ph_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_re_r <= a_re_nxt; a_im_r <= a_im_nxt; b_re_r <= b_re_nxt; b_im_r <= b_im_nxt;
    nx_r <= nx_nxt; d_r <= d_nxt; nre_r <= nre_nxt; nim_r <= nim_nxt;
    q_re_r <= q_re_nxt; q_im_r <= q_im_nxt; acc_r <= acc_nxt;
    dnum_r <= dnum_nxt; drem_r <= drem_nxt; dquo_r <= dquo_nxt; dneg_r <= dneg_nxt;
    g_re_r <= g_re_nxt; g_im_r <= g_im_nxt;
  end

  // Outputs.
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    out_valid   = ovalid_r;
    out_gcd_re  = g_re_r;
    out_gcd_im  = g_im_r;
    out_coprime = ((g_re_r == 32'sd1 || g_re_r == -32'sd1) && g_im_r == '0) ||
                  ((g_im_r == 32'sd1 || g_im_r == -32'sd1) && g_re_r == '0);
  end

  // Input is only taken when idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_NORM_X))
    else $error("input transfer did not start a computation");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_gcd_re) && $stable(out_gcd_im)))
    else $error("result changed while stalled");

  // The divider only counts in the division states, and there its count stays within DivSteps.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_RE || state_r == ST_DIV_IM) |-> (dcnt_r <= DcntBits'(DivSteps)))
    else $error("divider step count out of range");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gig_pkg::*;

  localparam int unsigned NRand = 1500;

  // Clock and reset
  logic clk;
  logic rst_n;

  // Operand channel
  logic in_valid;
  logic in_stall;
  logic signed [CompBits-1:0] in_x_re, in_x_im, in_y_re, in_y_im;

  // Result channel
  logic out_valid;
  logic out_stall;
  logic signed [OutBits-1:0] out_gcd_re, out_gcd_im;
  logic out_coprime;

  gaussian_integer_gcd_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_re(in_x_re), .in_x_im(in_x_im), .in_y_re(in_y_re), .in_y_im(in_y_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_gcd_re(out_gcd_re), .out_gcd_im(out_gcd_im), .out_coprime(out_coprime)
  );

  typedef struct {
    logic signed [OutBits-1:0] re;
    logic signed [OutBits-1:0] im;
    logic                      unit;
  } gcd_res_t;

  // One row of the directed table; has_gold marks rows with a typed-in answer.
  typedef struct {
    longint xr, xi, yr, yi;
    bit has_gold;
    longint gr, gi;
    bit gu;
  } op_row_t;

  gcd_res_t gcd_q[$];
  int       n_bad;
  bit       send_done;
  // Set once by the sender; the receiver then holds off for a long stretch.
  bit       hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Rounded division, half away from zero; den > 0.
  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // Euclid loop over Gaussian integers; the larger norm is the dividend.
  function automatic gcd_res_t gauss_gcd(longint xr, longint xi, longint yr, longint yi);
    longint ar, ai, br, bi, dn, nr, ni, qr, qi, rr, ri;
    gcd_res_t res;
    if (xr * xr + xi * xi < yr * yr + yi * yi) begin
      ar = yr; ai = yi; br = xr; bi = xi;
    end else begin
      ar = xr; ai = xi; br = yr; bi = yi;
    end
    while (br != 0 || bi != 0) begin
      dn = br * br + bi * bi;
      nr = ar * br + ai * bi;
      ni = ai * br - ar * bi;
      qr = div_round(nr, dn);
      qi = div_round(ni, dn);
      rr = ar - (br * qr - bi * qi);
      ri = ai - (br * qi + bi * qr);
      ar = br; ai = bi; br = rr; bi = ri;
    end
    res.re = ar[OutBits-1:0];
    res.im = ai[OutBits-1:0];
    res.unit = ((ar == 1 || ar == -1) && ai == 0) || ((ai == 1 || ai == -1) && ar == 0);
    return res;
  endfunction

  // Random component: mostly small magnitudes (more nontrivial gcds),
  // sometimes full range so every bit toggles.
  function automatic longint rand_comp();
    logic signed [CompBits-1:0] v;
    case ($urandom_range(3))
      0: v = CompBits'($urandom);
      1: v = CompBits'($signed($urandom_range(2000)) - 1000);
      2: v = CompBits'($signed($urandom_range(200000)) - 100000);
      default: v = CompBits'($signed($urandom_range(20)) - 10);
    endcase
    return v;
  endfunction

  // Present one operand pair and wait for its transfer; valid stays up for
  // a pair that follows with no gap.
  task automatic put_ops(longint xr, longint xi, longint yr, longint yi);
    int gap;
    gap = $urandom_range(9);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_re <= xr[CompBits-1:0];
    in_x_im <= xi[CompBits-1:0];
    in_y_re <= yr[CompBits-1:0];
    in_y_im <= yi[CompBits-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Scale a random Gaussian integer g by two cofactors to get a known common factor.
  task automatic put_shared_pred();
    longint gr, gi, ar, ai, br, bi;
    gr = $signed($urandom_range(400)) - 200;
    gi = $signed($urandom_range(400)) - 200;
    ar = $signed($urandom_range(400)) - 200;
    ai = $signed($urandom_range(400)) - 200;
    br = $signed($urandom_range(400)) - 200;
    bi = $signed($urandom_range(400)) - 200;
    gcd_q.push_back(gauss_gcd(gr * ar - gi * ai, gr * ai + gi * ar,
                              gr * br - gi * bi, gr * bi + gi * br));
    put_ops(gr * ar - gi * ai, gr * ai + gi * ar, gr * br - gi * bi, gr * bi + gi * br);
  endtask

  localparam longint MaxC = 1073741823;
  localparam longint MinC = -1073741824;

  op_row_t dir_tab [20] = '{
    '{0, 0, 0, 0, 1, 0, 0, 0},              // both zero
    '{5, -3, 0, 0, 1, 5, -3, 0},            // y zero returns x
    '{0, 0, -7, 2, 1, -7, 2, 0},            // x zero returns y
    '{1, 0, 0, 0, 1, 1, 0, 1},              // unit
    '{0, 0, 0, -1, 1, 0, -1, 1},            // unit -i
    '{MaxC, MaxC, 0, 0, 1, MaxC, MaxC, 0},
    '{MinC, MinC, 0, 0, 1, MinC, MinC, 0},
    '{0, 0, MinC, MaxC, 1, MinC, MaxC, 0},
    '{MinC, MinC, MinC, MinC, 0, 0, 0, 0},
    '{MaxC, MinC, MinC, MaxC, 0, 0, 0, 0},
    '{MaxC, MaxC, MaxC, MinC, 0, 0, 0, 0},
    '{MinC, 0, 0, MinC, 0, 0, 0, 0},        // equal norms
    '{3, 4, 4, 3, 0, 0, 0, 0},              // equal norms
    '{3, 0, 2, 0, 0, 0, 0, 0},              // half rounds away
    '{-3, 0, 2, 0, 0, 0, 0, 0},
    '{0, 5, 0, 2, 0, 0, 0, 0},
    '{1, 1, 2, 0, 0, 0, 0, 0},
    '{12, 0, 8, 0, 0, 0, 0, 0},
    '{-1, 0, MaxC, MaxC, 0, 0, 0, 0},
    '{MaxC, 1, MaxC - 1, 0, 0, 0, 0, 0}
  };

  // Sender: directed table, then random pairs.
  initial begin
    gcd_res_t er;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_re = '0; in_x_im = '0; in_y_re = '0; in_y_im = '0;
    send_done = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_gold) begin
        er.re = dir_tab[i].gr[OutBits-1:0];
        er.im = dir_tab[i].gi[OutBits-1:0];
        er.unit = dir_tab[i].gu;
      end else begin
        er = gauss_gcd(dir_tab[i].xr, dir_tab[i].xi, dir_tab[i].yr, dir_tab[i].yi);
      end
      gcd_q.push_back(er);
      put_ops(dir_tab[i].xr, dir_tab[i].xi, dir_tab[i].yr, dir_tab[i].yi);
    end
    for (int n = 0; n < NRand; n++) begin
      if (n == 200) hold_req = 1'b1;
      // Queue the prediction as the pair is presented; values latch below.
      if ($urandom_range(2) == 0) begin
        put_shared_pred();
      end else begin
        longint a, b, c, d;
        a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
        if ($urandom_range(30) == 0) c = 0;
        if ($urandom_range(30) == 0) begin a = 0; b = 0; end
        gcd_q.push_back(gauss_gcd(a, b, c, d));
        put_ops(a, b, c, d);
      end
    end
    in_valid <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver: random stall per result, one long hold-off once.
  initial begin
    int wait_cyc;
    bit held;
    out_stall = 1'b1;
    held = 1'b0;
    n_bad = 0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (25000) @(posedge clk);
      end
      wait_cyc = ($urandom_range(4) == 0) ? 0 : $urandom_range(9);
      if (wait_cyc > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cyc) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      // out_valid is high and out_stall is low here, so this is the result being transferred.
      if (gcd_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result re=%0d im=%0d", out_gcd_re, out_gcd_im);
      end else begin
        gcd_res_t e;
        e = gcd_q.pop_front();
        if (out_gcd_re !== e.re || out_gcd_im !== e.im || out_coprime !== e.unit) begin
          n_bad++;
          if (n_bad <= 10)
            $display("gcd mismatch: exp %0d %0d %0b got %0d %0d %0b",
                     e.re, e.im, e.unit, out_gcd_re, out_gcd_im, out_coprime);
        end
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    wait (send_done);
    while (gcd_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/gig_pkg.sv
src/gaussian_integer_gcd_unit.sv
bench/tb_top.sv
